// ----- design/fsub_pkg.sv -----
// package: shared types and constants of the first substring match block
`default_nettype none

package fsub_pkg;

  localparam int LEN_W       = 5;
  localparam int REG_W       = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int START_W     = 16;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LENGTH = 2'd0,
    REG_LOW    = 2'd1,
    REG_HIGH   = 2'd2
  } fsub_reg_t;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] match_start;
  } fsub_res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fsub_qstat_t;

endpackage

`default_nettype wire

// ----- design/fsub_if.sv -----
// interfaces: text byte request channel and result request channel
`default_nettype none

interface fsub_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface fsub_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] match_start;

  modport source (output valid, output found, output match_start, input ready);
  modport sink   (input valid, input found, input match_start, output ready);
endinterface

`default_nettype wire

// ----- design/fsub_front.sv -----
// front end: config registers, byte window, position counter, parallel compare
`default_nettype none

module fsub_front #(
  parameter int MAX_PATTERN = 16,
  parameter int MAX_TEXT    = 65536
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [fsub_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fsub_pkg::REG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  input  wire logic [7:0]                    in_text_byte,
  input  wire logic                          in_end_of_text,
  output logic                               in_ready,
  input  wire fsub_pkg::fsub_qstat_t          q_stat,
  output logic                               push,
  output fsub_pkg::fsub_res_t                 push_item
);
  import fsub_pkg::*;

  localparam int CNT_W = $clog2(MAX_TEXT);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TEXT - 1);

  logic [LEN_W-1:0]   len_r;
  logic [REG_W-1:0]   pat_low_r;
  logic [REG_W-1:0]   pat_high_r;
  logic [7:0]         win_r   [MAX_PATTERN];
  logic [7:0]         win_nxt [MAX_PATTERN];
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic               done_r;
  logic               done_nxt;

  logic [LEN_W-1:0]   used_len;
  logic [2*REG_W-1:0] pat_all;
  logic [LEN_W-1:0]   sel;
  logic               bytes_eq;
  logic [CMP_W-1:0]   pos_ext;
  logic [CMP_W-1:0]   lm1_ext;
  logic [CMP_W-1:0]   start_ext;
  logic               hit;
  logic               accept;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= LEN_W'(1);
      pat_low_r  <= '0;
      pat_high_r <= '0;
    end else if (cfg_we) begin
      case (fsub_reg_t'(cfg_index))
        REG_LENGTH: len_r      <= cfg_data[LEN_W-1:0];
        REG_LOW:    pat_low_r  <= cfg_data;
        REG_HIGH:   pat_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (len_r == '0) begin
      used_len = LEN_W'(1);
    end else if (len_r > LEN_W'(MAX_PATTERN)) begin
      used_len = LEN_W'(MAX_PATTERN);
    end else begin
      used_len = len_r;
    end
  end

  assign pat_all  = {pat_high_r, pat_low_r};
  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  // window after the shift, newest byte in entry 0
  always_comb begin
    win_nxt[0] = in_text_byte;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      win_nxt[j] = win_r[j-1];
    end
  end

  always_comb begin
    bytes_eq = 1'b1;
    sel      = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      sel = used_len - LEN_W'(1) - LEN_W'(k);
      if (LEN_W'(k) < used_len) begin
        if (win_nxt[sel[IDX_W-1:0]] != pat_all[8*k +: 8]) begin
          bytes_eq = 1'b0;
        end
      end
    end
  end

  assign pos_ext   = CMP_W'(cnt_r);
  assign lm1_ext   = CMP_W'(used_len - LEN_W'(1));
  assign start_ext = pos_ext - lm1_ext;
  assign hit       = !done_r && (cnt_r < CNT_MAX) && (pos_ext >= lm1_ext) && bytes_eq;

  assign push                  = accept && (hit || (in_end_of_text && !done_r));
  assign push_item.found       = hit;
  assign push_item.match_start = hit ? START_W'(start_ext) : '0;

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = done_r;
    if (accept) begin
      if (in_end_of_text) begin
        cnt_nxt  = '0;
        done_nxt = 1'b0;
      end else begin
        if (cnt_r < CNT_MAX) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        done_nxt = done_r || hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // window data needs no reset, validity follows the count
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        win_r[j] <= win_nxt[j];
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/fsub_queue.sv -----
// result queue between front end and output stage
`default_nettype none

module fsub_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire fsub_pkg::fsub_res_t  push_item,
  input  wire logic                 pop,
  output fsub_pkg::fsub_res_t       pop_item,
  output fsub_pkg::fsub_qstat_t     q_stat
);
  import fsub_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  fsub_res_t        mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign q_stat.full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_item     = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ----- design/fsub_back.sv -----
// output stage: result register driving the result channel
`default_nettype none

module fsub_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire fsub_pkg::fsub_qstat_t q_stat,
  input  wire fsub_pkg::fsub_res_t  pop_item,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output fsub_pkg::fsub_res_t       out_item
);
  import fsub_pkg::*;

  logic      valid_r;
  fsub_res_t item_r;
  logic      load;

  assign load      = !q_stat.empty && (!valid_r || out_ready);
  assign pop       = load;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= pop_item;
    end
  end

endmodule

`default_nettype wire

// ----- design/first_substring_match.sv -----
// top level: streaming first-occurrence substring search
//
//   channel   dir   handshake              payload
//   in_ch     in    valid/ready            text_byte[7:0], end_of_text
//   out_ch    out   valid/ready            found, match_start[15:0]
//   cfg_*     in    cfg_we (no wait)       cfg_index[1:0], cfg_data[63:0]
//
// one byte per cycle unless the queue is full; window shift and full compare in the same cycle
// a result reaches out_ch through the queue and then the output register
// rst_n is synchronous; it clears counter, done flag, queue and output valid, no clearing pass
// in_ch stalls only when the two-entry result queue is full
`default_nettype none

module first_substring_match #(
  parameter int MAX_PATTERN = 16,
  parameter int MAX_TEXT    = 65536
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [fsub_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fsub_pkg::REG_W-1:0]     cfg_data,
  fsub_in_if.sink                             in_ch,
  fsub_out_if.source                          out_ch
);
  import fsub_pkg::*;

  fsub_qstat_t q_stat;
  fsub_res_t   push_item;
  fsub_res_t   pop_item;
  fsub_res_t   out_item;
  logic        push;
  logic        pop;

  fsub_front #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_TEXT    (MAX_TEXT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_ch.valid),
    .in_text_byte   (in_ch.text_byte),
    .in_end_of_text (in_ch.end_of_text),
    .in_ready       (in_ch.ready),
    .q_stat         (q_stat),
    .push           (push),
    .push_item      (push_item)
  );

  fsub_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  fsub_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop_item  (pop_item),
    .pop       (pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  assign out_ch.found       = out_item.found;
  assign out_ch.match_start = out_item.match_start;

endmodule

`default_nettype wire
